/* sv/ldr_pkg.sv */
// ldr_pkg: shared constants, item type and helpers for the duplicate remover
// used by ldr_cell, ldr_out and list_duplicate_remover_unit
`timescale 1ns / 1ps

package ldr_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int KEY_BITS  = 32;

    localparam int KEY_W     = 32;
    localparam int KEY_CMP_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int POS_W     = 6;
    localparam int DEL_W     = 7;
    localparam logic [DEL_W-1:0] DROP_MAX = {DEL_W{1'b1}};

    // output word layout, lowest bit first
    localparam int OUT_POS_LSB  = KEY_W;
    localparam int OUT_DEL_LSB  = KEY_W + POS_W;
    localparam int OUT_USED_W   = KEY_W + POS_W + DEL_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;
    localparam int USER_KEEP    = 0;
    localparam int USER_OVF     = 1;

    // word travelling down the cell row
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             empty;
        logic             last;
        logic             matched;
        logic             kept;
        logic [POS_W-1:0] pos;
    } item_t;

    function automatic logic [POS_W-1:0] pos_of(input logic [IDX_W-1:0] idx);
        return POS_W'(idx);
    endfunction

endpackage

/* sv/list_duplicate_remover_unit.sv */
// list_duplicate_remover_unit: keep-first deduplication over a row of key cells
// a result passes through the word register of every cell and then the result register
// throughput: one word per cycle; the cell row and result stage move in lockstep,
// so a stalled output freezes the whole row and s_tready drops with it
// reset: rst_n clears slot valid bits, word valid bits and the deletion count
// depends on ldr_pkg, ldr_cell, ldr_out
`timescale 1ns / 1ps

module list_duplicate_remover_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ldr_pkg::KEY_W-1:0]       s_tdata,   // key_bytes
    input  logic                            s_tuser,   // is_empty
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ldr_pkg::OUT_TDATA_W-1:0] m_tdata,   // key_echo, out_position, deleted_so_far
    output logic [1:0]                      m_tuser,   // keep, overflow
    output logic                            m_tlast
);

    logic           advance;
    ldr_pkg::item_t chain [0:ldr_pkg::MAX_ITEMS];

    assign chain[0].valid   = s_tvalid;
    assign chain[0].key     = s_tdata;
    assign chain[0].empty   = s_tuser;
    assign chain[0].last    = s_tlast;
    assign chain[0].matched = 1'b0;
    assign chain[0].kept    = 1'b0;
    assign chain[0].pos     = '0;

    generate
        for (genvar k = 0; k < ldr_pkg::MAX_ITEMS; k++)
        begin : g_cell
            ldr_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .idx      (ldr_pkg::IDX_W'(k)),
                .in_item  (chain[k]),
                .out_item (chain[k+1])
            );
        end
    endgenerate

    ldr_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (chain[ldr_pkg::MAX_ITEMS]),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign s_tready = advance;

    // keep and overflow never together
    a_keep_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[ldr_pkg::USER_KEEP] && m_tuser[ldr_pkg::USER_OVF]))
        else $error("keep and overflow both set");

    // a dropped or overflowed word carries position zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[ldr_pkg::USER_KEEP]) |->
        (m_tdata[ldr_pkg::OUT_DEL_LSB-1:ldr_pkg::OUT_POS_LSB] == '0))
        else $error("position set on a word that was not kept");

    // input side moves only when the result register can take a word
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stage");

    // a stalled result holds its deletion count
    a_hold_del: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
        $stable(m_tdata[ldr_pkg::OUT_USED_W-1:ldr_pkg::OUT_DEL_LSB]))
        else $error("deletion count changed under stall");

endmodule

/* sv/ldr_cell.sv */
// ldr_cell: one slot of the key store plus the word register feeding the next slot
// depends on ldr_pkg
`timescale 1ns / 1ps

module ldr_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [ldr_pkg::IDX_W-1:0]  idx,
    input  ldr_pkg::item_t             in_item,
    output ldr_pkg::item_t             out_item
);

    logic                          slot_valid_reg;
    logic                          slot_valid_next;
    logic [ldr_pkg::KEY_CMP_W-1:0] key_reg;
    logic [ldr_pkg::KEY_CMP_W-1:0] key_next;
    ldr_pkg::item_t                item_reg;
    ldr_pkg::item_t                item_next;
    logic                          open_word;
    logic                          hit;
    logic                          claim;

    // a word still looking for a home or a match
    assign open_word = in_item.valid && !in_item.empty && !in_item.matched && !in_item.kept;
    assign hit   = open_word && slot_valid_reg &&
                   (key_reg == in_item.key[ldr_pkg::KEY_CMP_W-1:0]);
    assign claim = open_word && !slot_valid_reg;

    always_comb
    begin
        item_next       = in_item;
        slot_valid_next = slot_valid_reg;
        key_next        = key_reg;
        if (hit)
        begin
            item_next.matched = 1'b1;
        end
        if (claim)
        begin
            item_next.kept = 1'b1;
            item_next.pos  = ldr_pkg::pos_of(idx);
            key_next       = in_item.key[ldr_pkg::KEY_CMP_W-1:0];
            slot_valid_next = 1'b1;
        end
        // the last word of a list empties each slot as it passes
        if (in_item.valid && in_item.last)
        begin
            slot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            item_reg       <= '0;
        end
        else if (advance)
        begin
            slot_valid_reg <= slot_valid_next;
            item_reg       <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_next;
        end
    end

    assign out_item = item_reg;

endmodule

/* sv/ldr_out.sv */
// ldr_out: result stage, keeps the deletion count and holds the output word
// depends on ldr_pkg
`timescale 1ns / 1ps

module ldr_out
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ldr_pkg::item_t                  in_item,
    output logic                            advance,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ldr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    logic                      valid_reg;
    logic [ldr_pkg::DEL_W-1:0] drop_cnt_reg;
    logic [ldr_pkg::DEL_W-1:0] drop_cnt_next;
    logic [ldr_pkg::DEL_W-1:0] del_sum;
    logic [ldr_pkg::KEY_W-1:0] key_reg;
    logic [ldr_pkg::POS_W-1:0] pos_reg;
    logic [ldr_pkg::DEL_W-1:0] del_reg;
    logic                      keep_reg;
    logic                      ovf_reg;
    logic                      last_reg;
    logic                      dropped;
    logic                      ovf;

    assign advance = !valid_reg || m_tready;
    assign dropped = in_item.empty || in_item.matched;
    // reached the end of the row with no slot left
    assign ovf     = !in_item.empty && !in_item.matched && !in_item.kept;

    always_comb
    begin
        del_sum = drop_cnt_reg;
        if (dropped && (drop_cnt_reg != ldr_pkg::DROP_MAX))
        begin
            del_sum = drop_cnt_reg + ldr_pkg::DEL_W'(1);
        end
        drop_cnt_next = drop_cnt_reg;
        if (in_item.valid)
        begin
            drop_cnt_next = in_item.last ? '0 : del_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            drop_cnt_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg    <= in_item.valid;
            drop_cnt_reg <= drop_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item.valid)
        begin
            key_reg  <= in_item.key;
            pos_reg  <= in_item.kept ? in_item.pos : '0;
            del_reg  <= del_sum;
            keep_reg <= in_item.kept;
            ovf_reg  <= ovf;
            last_reg <= in_item.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{ldr_pkg::OUT_PAD_W{1'b0}}, del_reg, pos_reg, key_reg};
    assign m_tuser  = {ovf_reg, keep_reg};
    assign m_tlast  = last_reg;

endmodule

/* tb/ldr_checker.sv */
// ldr_checker: watches both stream channels of the duplicate remover, predicts each
// result word from the accepted input words and compares field by field
// depends on ldr_pkg for widths and the output word layout
`timescale 1ns / 1ps

module ldr_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ldr_pkg::KEY_W-1:0]       s_tdata,   // key_bytes
    input  logic                            s_tuser,   // is_empty
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ldr_pkg::OUT_TDATA_W-1:0] m_tdata,   // key_echo, out_position, deleted_so_far
    input  logic [1:0]                      m_tuser,   // keep, overflow
    input  logic                            m_tlast,
    output int                              mismatches,
    output int                              pending,
    output int                              results_checked,
    output int                              kept_seen,
    output int                              overflow_seen,
    output int                              saturated_seen
);

    typedef struct packed {
        logic [ldr_pkg::KEY_W-1:0] key_echo;
        logic                      keep;
        logic [ldr_pkg::POS_W-1:0] position;
        logic [ldr_pkg::DEL_W-1:0] deleted;
        logic                      end_of_list;
        logic                      overflow;
    } dedup_result_t;

    localparam logic [ldr_pkg::KEY_W-1:0] CMP_MASK =
        (ldr_pkg::KEY_CMP_W >= ldr_pkg::KEY_W) ? {ldr_pkg::KEY_W{1'b1}} :
        ((ldr_pkg::KEY_W'(1) << ldr_pkg::KEY_CMP_W) - ldr_pkg::KEY_W'(1));

    // keys kept so far in the current list, only entries below kept_keys are valid
    logic [ldr_pkg::KEY_W-1:0] seen_store [ldr_pkg::MAX_ITEMS];
    int                        kept_keys;
    logic [ldr_pkg::DEL_W-1:0] drop_count;
    dedup_result_t             expected_results [$];
    int                        fail_total;
    int                        checked_total;
    int                        kept_total;
    int                        overflow_total;
    int                        saturated_total;

    function automatic dedup_result_t predict_dedup(input logic [ldr_pkg::KEY_W-1:0] key,
                                                     input logic empty, input logic last);
        dedup_result_t res;
        logic          found;
        found = 1'b0;
        for (int i = 0; i < kept_keys; i++)
        begin
            if ((seen_store[i] & CMP_MASK) == (key & CMP_MASK))
                found = 1'b1;
        end
        res.key_echo    = key;
        res.keep        = 1'b0;
        res.position    = '0;
        res.end_of_list = last;
        res.overflow    = 1'b0;
        if (empty || found)
        begin
            if (drop_count != ldr_pkg::DROP_MAX)
                drop_count = drop_count + ldr_pkg::DEL_W'(1);
        end
        else if (kept_keys >= ldr_pkg::MAX_ITEMS)
        begin
            res.overflow = 1'b1;
        end
        else
        begin
            seen_store[kept_keys] = key & CMP_MASK;
            res.keep     = 1'b1;
            res.position = ldr_pkg::POS_W'(kept_keys);
            kept_keys++;
        end
        res.deleted = drop_count;
        if (last)
        begin
            kept_keys  = 0;
            drop_count = '0;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [ldr_pkg::KEY_W-1:0] want,
                               input logic [ldr_pkg::KEY_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dedup_result_t want;
        dedup_result_t got;
        if (!rst_n)
        begin
            kept_keys  = 0;
            drop_count = '0;
            expected_results.delete();
        end
        else
        begin
            // result side first: a word accepted now cannot come out in the same cycle
            if (m_tvalid && m_tready)
            begin
                got.key_echo    = m_tdata[ldr_pkg::KEY_W-1:0];
                got.position    = m_tdata[ldr_pkg::OUT_POS_LSB +: ldr_pkg::POS_W];
                got.deleted     = m_tdata[ldr_pkg::OUT_DEL_LSB +: ldr_pkg::DEL_W];
                got.keep        = m_tuser[ldr_pkg::USER_KEEP];
                got.overflow    = m_tuser[ldr_pkg::USER_OVF];
                got.end_of_list = m_tlast;
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none actual 0x%0h",
                             $time, got);
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("key_echo", want.key_echo, got.key_echo);
                    check_field("keep", ldr_pkg::KEY_W'(want.keep),
                                ldr_pkg::KEY_W'(got.keep));
                    check_field("out_position", ldr_pkg::KEY_W'(want.position),
                                ldr_pkg::KEY_W'(got.position));
                    check_field("deleted_so_far", ldr_pkg::KEY_W'(want.deleted),
                                ldr_pkg::KEY_W'(got.deleted));
                    check_field("end_of_list", ldr_pkg::KEY_W'(want.end_of_list),
                                ldr_pkg::KEY_W'(got.end_of_list));
                    check_field("overflow", ldr_pkg::KEY_W'(want.overflow),
                                ldr_pkg::KEY_W'(got.overflow));
                    checked_total++;
                    if (want.keep)
                        kept_total++;
                    if (want.overflow)
                        overflow_total++;
                    if (want.deleted == ldr_pkg::DROP_MAX)
                        saturated_total++;
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_dedup(s_tdata, s_tuser, s_tlast));
        end
        mismatches      <= fail_total;
        pending         <= expected_results.size();
        results_checked <= checked_total;
        kept_seen       <= kept_total;
        overflow_seen   <= overflow_total;
        saturated_seen  <= saturated_total;
    end

endmodule

/* tb/testbench.sv */
// testbench: stimulus and verdict for list_duplicate_remover_unit
// drives directed and random lists under varying idle patterns; ldr_checker does the checking
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD = 6;
    localparam int SETTLE_CYCLES = 2 * ldr_pkg::MAX_ITEMS + 16;
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ldr_pkg::KEY_W-1:0]       s_tdata = '0;    // key_bytes
    logic                            s_tuser = 1'b0;  // is_empty
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ldr_pkg::OUT_TDATA_W-1:0] m_tdata;         // key_echo, out_position, deleted_so_far
    logic [1:0]                      m_tuser;         // keep, overflow
    logic                            m_tlast;

    int mismatches;
    int pending;
    int results_checked;
    int kept_seen;
    int overflow_seen;
    int saturated_seen;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int words_sent = 0;
    int lists_sent = 0;

    always #HALF_PERIOD clk = ~clk;

    list_duplicate_remover_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ldr_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .kept_seen       (kept_seen),
        .overflow_seen   (overflow_seen),
        .saturated_seen  (saturated_seen)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);

    task automatic send_word(input logic [ldr_pkg::KEY_W-1:0] key, input logic empty,
                             input logic last);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= empty;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (last)
            lists_sent++;
    endtask

    // hold the sender off until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // more distinct keys than the store holds, with copies and empties mixed into the tail
    task automatic send_overflow_list();
        logic [ldr_pkg::KEY_W-1:0] base;
        int                        n_new;
        int                        len;
        int                        sel;
        base  = $urandom();
        n_new = ldr_pkg::MAX_ITEMS + $urandom_range(1, 12);
        len   = n_new + $urandom_range(2, 8);
        for (int i = 0; i < len; i++)
        begin
            if (i < n_new)
            begin
                send_word(base ^ ldr_pkg::KEY_W'(i), 1'b0, i == len - 1);
            end
            else
            begin
                sel = $urandom_range(2);
                if (sel == 0)
                    send_word(base ^ ldr_pkg::KEY_W'($urandom_range(ldr_pkg::MAX_ITEMS - 1)),
                              1'b0, i == len - 1);
                else if (sel == 1)
                    send_word(base ^ ldr_pkg::KEY_W'($urandom_range(ldr_pkg::MAX_ITEMS,
                              n_new - 1)), 1'b0, i == len - 1);
                else
                    send_word($urandom(), 1'b1, i == len - 1);
            end
        end
    endtask

    // enough drops to push the deletion count into saturation
    task automatic send_saturating_list();
        logic [ldr_pkg::KEY_W-1:0] pool [4];
        int                        len;
        for (int i = 0; i < 4; i++)
            pool[i] = $urandom();
        len = $urandom_range(135, 160);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(1) == 0)
                send_word($urandom(), 1'b1, i == len - 1);
            else
                send_word(pool[$urandom_range(3)], 1'b0, i == len - 1);
        end
    endtask

    task automatic send_random_list();
        logic [ldr_pkg::KEY_W-1:0] pool [16];
        int                        pool_size;
        int                        len;
        pool_size = $urandom_range(1, 16);
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
        for (int i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(3))
                0:       pool[i] = {24'd0, 8'($urandom_range(32, 126))};
                1:       pool[i] = (i > 0) ? pool[$urandom_range(i - 1)] ^
                                   (ldr_pkg::KEY_W'(1) << $urandom_range(ldr_pkg::KEY_W - 1)) :
                                   ldr_pkg::KEY_W'($urandom());
                default: pool[i] = $urandom();
            endcase
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 15)
                send_word($urandom(), 1'b1, i == len - 1);
            else
                send_word(pool[$urandom_range(pool_size - 1)], 1'b0, i == len - 1);
        end
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input int word_target);
        int kind;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        send_overflow_list();
        send_saturating_list();
        while (words_sent < word_target)
        begin
            kind = $urandom_range(99);
            if (kind < 4)
                send_overflow_list();
            else if (kind < 8)
                send_saturating_list();
            else
                send_random_list();
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme keys, copies, empty slots with any key bits, single-word list
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'h0000_0001, 1'b0, 1'b0);
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0001, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        send_word(32'h4443_4241, 1'b0, 1'b0);
        send_word(32'h0000_4241, 1'b0, 1'b0);
        send_word(32'h4443_4241, 1'b0, 1'b0);
        send_word(32'h0000_0041, 1'b0, 1'b0);
        send_word(32'h5A5A_5A5A, 1'b1, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_word(32'hFFFF_FFFE, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0, 1'b1);
        drain();

        run_phase(16, 55, 430);
        run_phase(55, 16, 850);
        run_phase(0, 0, 1270);

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d words in %0d lists, checked %0d results", words_sent, lists_sent,
                 results_checked);
        $display("kept keys %0d, overflow drops %0d, saturated deletion counts %0d",
                 kept_seen, overflow_seen, saturated_seen);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/ldr_pkg.sv
sv/ldr_cell.sv
sv/ldr_out.sv
sv/list_duplicate_remover_unit.sv
tb/ldr_checker.sv
tb/testbench.sv
